### sv/kce_pkg.sv
// Package for the k-means cluster engine.
// Holds operation and result-kind codes and the fixed field widths of the item ports.
// No dependencies.
package kce_pkg;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_TRAIN    = 2'd2,
    OP_UPDATE   = 2'd3
  } op_e;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  localparam int unsigned CLUSTER_W = 4;
  localparam int unsigned DIM_W     = 3;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned DIST_W    = 35;
  localparam int unsigned COST_W    = 48;
  localparam int unsigned EMPTY_W   = 5;
  localparam int unsigned NCLU_W    = 5;
  localparam int unsigned NDIM_W    = 4;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam logic [2:0] ADDR_NUM_CLUSTERS = 3'd0;
  localparam logic [2:0] ADDR_NUM_DIMS     = 3'd4;

endpackage

### sv/kmeans_cluster_engine_core.sv
// K-means cluster engine: one point coordinate updates all centroid distances.
// A coordinate is accepted, then one centroid RAM read per cluster feeds the squared-difference pipe.
// The last coordinate adds a minimum scan, sum updates for training and an output step,
// which waits while an earlier result item is still held.
// An update divides each sum of every non-empty cluster by its count into its centroid.
// Reset is asynchronous, active low: counts, cost, sum valid bits and control registers clear.
module kmeans_cluster_engine_core
  import kce_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = 16,
  parameter int unsigned MAX_DIMS     = 8,
  parameter int unsigned COORD_BITS   = 16,
  parameter int unsigned COUNT_BITS   = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cluster[3:0], dim[6:4], value[22:7], zero[23]
  input  logic [23:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // nearest_cluster[3:0], distance_sq[38:4], total_cost[86:39], empty_clusters[91:87]
  output logic [95:0] m_axis_tdata,
  // kind[0]
  output logic [0:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CI_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned KC_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned DI_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned DC_W  = $clog2(MAX_DIMS + 1);
  localparam int unsigned DEPTH = MAX_CLUSTERS * MAX_DIMS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = COUNT_BITS + 1;
  localparam int unsigned SUM_W = COORD_BITS + COUNT_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIST  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_TRAIN = 4'd3;
  localparam logic [3:0] S_UPC   = 4'd4;
  localparam logic [3:0] S_UPRD  = 4'd5;
  localparam logic [3:0] S_UPDW  = 4'd6;
  localparam logic [3:0] S_UPDIV = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]        state_q;
  logic [NCLU_W-1:0] nclu_q;
  logic [NDIM_W-1:0] ndim_q;
  logic [KC_W-1:0]   k_eff;
  logic [DC_W-1:0]   d_eff;

  logic [1:0]               in_op;
  logic [CLUSTER_W-1:0]     in_cl;
  logic [DIM_W-1:0]         in_dm;
  logic signed [COORD_BITS-1:0] in_coord;
  logic                     in_acc;
  logic                     in_cl_ok;
  logic                     in_dm_ok;

  logic [1:0]               op_q;
  logic [DI_W-1:0]          dm_q;
  logic signed [COORD_BITS-1:0] coord_q;
  logic signed [COORD_BITS-1:0] pbuf_q [MAX_DIMS];
  logic [DIST_W-1:0]        part_q [MAX_CLUSTERS];
  logic [CNT_W-1:0]         cnt_q [MAX_CLUSTERS];
  logic [MAX_DIMS-1:0]      sval_q [MAX_CLUSTERS];
  logic [COST_W-1:0]        cost_q;

  logic [KC_W-1:0]   c_q;
  logic [DC_W-1:0]   j_q;
  logic [CI_W-1:0]   rc_q;
  logic [CI_W-1:0]   sc_q;
  logic [DI_W-1:0]   jr_q;
  logic              rdv_q;
  logic              sqv_q;
  logic [DIST_W-1:0] sq_q;
  logic [DIST_W-1:0] best_q;
  logic [CI_W-1:0]   win_q;
  logic [EMPTY_W-1:0] empty_q;

  logic              res_kind_q;
  logic [CLUSTER_W-1:0] res_nc_q;
  logic [DIST_W-1:0] res_dist_q;
  logic [COST_W-1:0] res_cost_q;
  logic [EMPTY_W-1:0] res_empty_q;

  logic              mv_q;
  logic [95:0]       mdata_q;
  logic              mkind_q;
  logic              res_load;

  logic                  cen_we;
  logic [AW-1:0]         cen_waddr;
  logic [COORD_BITS-1:0] cen_wdata;
  logic [AW-1:0]         cen_raddr;
  logic [COORD_BITS-1:0] cen_rdata;
  logic                  sum_we;
  logic [AW-1:0]         sum_waddr;
  logic [SUM_W-1:0]      sum_wdata;
  logic [AW-1:0]         sum_raddr;
  logic [SUM_W-1:0]      sum_rdata;

  logic                  div_start;
  logic                  div_done;
  logic [SUM_W-1:0]      div_num;
  logic signed [SUM_W-1:0] div_quo;

  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS:0]  absd;
  logic [63:0]          absx;
  logic [35:0]          prod;
  logic [DIST_W-1:0]    sq_d;
  logic [DIST_W:0]      psum;
  logic [COST_W:0]      csum;
  logic                 cfg_we;
  logic                 win_full;
  logic [SUM_W-1:0]     sum_old;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nclu_q <= NCLU_W'(1);
      ndim_q <= NDIM_W'(1);
    end else if (cfg_we) begin
      if (paddr == ADDR_NUM_CLUSTERS) begin
        nclu_q <= pwdata[NCLU_W-1:0];
      end
      if (paddr == ADDR_NUM_DIMS) begin
        ndim_q <= pwdata[NDIM_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_NUM_CLUSTERS: prdata = 32'(nclu_q);
      ADDR_NUM_DIMS:     prdata = 32'(ndim_q);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    if (nclu_q == '0) begin
      k_eff = KC_W'(1);
    end else if (32'(nclu_q) > 32'(MAX_CLUSTERS)) begin
      k_eff = KC_W'(MAX_CLUSTERS);
    end else begin
      k_eff = KC_W'(nclu_q);
    end
    if (ndim_q == '0) begin
      d_eff = DC_W'(1);
    end else if (32'(ndim_q) > 32'(MAX_DIMS)) begin
      d_eff = DC_W'(MAX_DIMS);
    end else begin
      d_eff = DC_W'(ndim_q);
    end
  end

  // Input decode.
  assign in_op    = s_axis_tuser;
  assign in_cl    = s_axis_tdata[3:0];
  assign in_dm    = s_axis_tdata[6:4];
  assign in_coord = COORD_BITS'(signed'(s_axis_tdata[22:7]));
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_cl_ok = 32'(in_cl) < 32'(k_eff);
  assign in_dm_ok = 32'(in_dm) < 32'(d_eff);
  assign s_axis_tready = (state_q == S_IDLE);

  // Squared difference of the point coordinate and one centroid coordinate.
  assign diff = (COORD_BITS+1)'(coord_q) - (COORD_BITS+1)'(signed'(cen_rdata));
  assign absd = diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : (COORD_BITS+1)'(diff);
  assign absx = 64'(absd);
  assign prod = 36'(absx[17:0]) * 36'(absx[17:0]);

  always_comb begin
    if ((|absx[63:18]) || (prod > 36'(DIST_MAX))) begin
      sq_d = DIST_MAX;
    end else begin
      sq_d = prod[DIST_W-1:0];
    end
  end

  assign psum = {1'b0, part_q[sc_q]} + {1'b0, sq_q};
  assign csum = {1'b0, cost_q} + {{(COST_W-DIST_W+1){1'b0}}, best_q};
  assign win_full = cnt_q[win_q][COUNT_BITS];
  // A sum entry not written since the last update reads as zero.
  assign sum_old  = sval_q[win_q][jr_q] ? sum_rdata : '0;
  assign div_num  = sval_q[c_q[CI_W-1:0]][j_q[DI_W-1:0]] ? sum_rdata : '0;

  // Memory ports.
  always_comb begin
    cen_we    = 1'b0;
    cen_waddr = AW'(32'(in_cl) * MAX_DIMS + 32'(in_dm));
    cen_wdata = in_coord;
    if (state_q == S_IDLE) begin
      cen_we = in_acc && (in_op == OP_LOAD) && in_cl_ok && in_dm_ok;
    end else if (state_q == S_UPDIV) begin
      cen_we    = div_done;
      cen_waddr = AW'(32'(c_q) * MAX_DIMS + 32'(j_q));
      cen_wdata = COORD_BITS'(div_quo);
    end
  end

  assign cen_raddr = AW'(32'(c_q) * MAX_DIMS + 32'(dm_q));
  assign sum_raddr = (state_q == S_TRAIN) ? AW'(32'(win_q) * MAX_DIMS + 32'(j_q))
                                          : AW'(32'(c_q) * MAX_DIMS + 32'(j_q));
  assign sum_we    = (state_q == S_TRAIN) && rdv_q;
  assign sum_waddr = AW'(32'(win_q) * MAX_DIMS + 32'(jr_q));
  assign sum_wdata = sum_old + SUM_W'(pbuf_q[jr_q]);
  assign div_start = (state_q == S_UPDW);

  kce_ram #(
    .WIDTH(COORD_BITS),
    .DEPTH(DEPTH)
  ) u_centroid_ram (
    .clk_i  (clk_i),
    .we_i   (cen_we),
    .waddr_i(cen_waddr),
    .wdata_i(cen_wdata),
    .raddr_i(cen_raddr),
    .rdata_o(cen_rdata)
  );

  kce_ram #(
    .WIDTH(SUM_W),
    .DEPTH(DEPTH)
  ) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (sum_we),
    .waddr_i(sum_waddr),
    .wdata_i(sum_wdata),
    .raddr_i(sum_raddr),
    .rdata_o(sum_rdata)
  );

  kce_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (signed'(div_num)),
    .den_i  (cnt_q[c_q[CI_W-1:0]]),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Output register.
  assign res_load = (state_q == S_DONE) && (!mv_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (res_load) begin
      mv_q <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      mv_q <= 1'b0;
    end
  end

  // Control sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      c_q     <= '0;
      j_q     <= '0;
      rdv_q   <= 1'b0;
      sqv_q   <= 1'b0;
      cost_q  <= '0;
      empty_q <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cnt_q[i]  <= '0;
        sval_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          c_q   <= '0;
          j_q   <= '0;
          rdv_q <= 1'b0;
          sqv_q <= 1'b0;
          if (in_acc) begin
            if (in_op == OP_UPDATE) begin
              empty_q <= '0;
              state_q <= S_UPC;
            end else if (in_op != OP_LOAD && in_dm_ok) begin
              state_q <= S_DIST;
            end
          end
        end
        S_DIST: begin
          if (c_q < k_eff) begin
            c_q   <= c_q + 1'b1;
            rdv_q <= 1'b1;
          end else begin
            rdv_q <= 1'b0;
          end
          sqv_q <= rdv_q;
          if (c_q == k_eff && !rdv_q && !sqv_q) begin
            c_q     <= '0;
            state_q <= (32'(dm_q) == 32'(d_eff) - 1) ? S_SCAN : S_IDLE;
          end
        end
        S_SCAN: begin
          if (c_q < k_eff) begin
            c_q <= c_q + 1'b1;
          end else if (op_q == OP_TRAIN) begin
            j_q     <= '0;
            rdv_q   <= 1'b0;
            state_q <= S_TRAIN;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_TRAIN: begin
          if (!win_full && j_q < d_eff) begin
            j_q   <= j_q + 1'b1;
            rdv_q <= 1'b1;
          end else begin
            rdv_q <= 1'b0;
          end
          if (rdv_q) begin
            sval_q[win_q][jr_q] <= 1'b1;
          end
          if (win_full || (j_q == d_eff && !rdv_q)) begin
            if (!win_full) begin
              cnt_q[win_q] <= cnt_q[win_q] + 1'b1;
            end
            cost_q  <= csum[COST_W] ? COST_MAX : csum[COST_W-1:0];
            state_q <= S_DONE;
          end
        end
        S_UPC: begin
          if (c_q == k_eff) begin
            cost_q <= '0;
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
              cnt_q[i]  <= '0;
              sval_q[i] <= '0;
            end
            state_q <= S_DONE;
          end else if (cnt_q[c_q[CI_W-1:0]] == '0) begin
            empty_q <= empty_q + 1'b1;
            c_q     <= c_q + 1'b1;
          end else begin
            j_q     <= '0;
            state_q <= S_UPRD;
          end
        end
        S_UPRD: begin
          state_q <= S_UPDW;
        end
        S_UPDW: begin
          state_q <= S_UPDIV;
        end
        S_UPDIV: begin
          if (div_done) begin
            if (j_q + 1'b1 == d_eff) begin
              j_q     <= '0;
              c_q     <= c_q + 1'b1;
              state_q <= S_UPC;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= S_UPRD;
            end
          end
        end
        S_DONE: begin
          if (res_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc) begin
      op_q    <= in_op;
      dm_q    <= DI_W'(in_dm);
      coord_q <= in_coord;
      if (in_op != OP_LOAD && in_op != OP_UPDATE && in_dm_ok) begin
        pbuf_q[DI_W'(in_dm)] <= in_coord;
      end
    end
    rc_q <= c_q[CI_W-1:0];
    sc_q <= rc_q;
    jr_q <= j_q[DI_W-1:0];
    if (state_q == S_DIST) begin
      if (rdv_q) begin
        sq_q <= sq_d;
      end
      if (sqv_q) begin
        if (dm_q == '0) begin
          part_q[sc_q] <= sq_q;
        end else begin
          part_q[sc_q] <= psum[DIST_W] ? DIST_MAX : psum[DIST_W-1:0];
        end
      end
    end
    if (state_q == S_SCAN && c_q < k_eff) begin
      if (c_q == '0 || part_q[c_q[CI_W-1:0]] < best_q) begin
        best_q <= part_q[c_q[CI_W-1:0]];
        win_q  <= c_q[CI_W-1:0];
      end
    end
    if (state_q == S_SCAN || state_q == S_TRAIN) begin
      res_kind_q  <= KIND_ASSIGN;
      res_nc_q    <= CLUSTER_W'(win_q);
      res_dist_q  <= best_q;
      res_cost_q  <= '0;
      res_empty_q <= '0;
    end
    if (state_q == S_UPC) begin
      res_kind_q  <= KIND_UPDATE;
      res_nc_q    <= '0;
      res_dist_q  <= '0;
      res_cost_q  <= cost_q;
      res_empty_q <= empty_q;
    end
    if (res_load) begin
      mkind_q <= res_kind_q;
      mdata_q <= {4'b0, res_empty_q, res_cost_q, res_dist_q, res_nc_q};
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = mkind_q;

endmodule

### sv/kce_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module kce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/kce_div.sv
// Iterative restoring divider: signed dividend by unsigned divisor, truncated toward zero.
// One quotient bit per cycle. No dependencies.
module kce_div #(
  parameter int unsigned NUM_W = 36,
  parameter int unsigned DEN_W = 21
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] mag_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W-1:0] den_q;
  logic             neg_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W+1:0] shifted;
  logic [DEN_W+1:0] diff;

  assign shifted = {rem_q, mag_q[NUM_W-1]};
  assign diff    = shifted - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      mag_q <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[DEN_W+1]) begin
        rem_q <= diff[DEN_W:0];
        mag_q <= {mag_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DEN_W:0];
        mag_q <= {mag_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -signed'(mag_q) : signed'(mag_q);

endmodule

### sv/kce_checker.sv
// Port-level checker for the k-means cluster engine, bound to the top level.
// Depends on kce_pkg and kmeans_cluster_engine_core.
module kce_checker
  import kce_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        pready
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item dropped or changed while stalled");

  a_upd_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] == KIND_UPDATE |-> m_axis_tdata[38:0] == '0)
    else $error("update result carries assignment fields");

  a_asg_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] == KIND_ASSIGN |-> m_axis_tdata[91:39] == '0)
    else $error("assignment result carries update fields");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[91:87] <= 5'd16)
    else $error("empty cluster count out of range");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("configuration port not ready");

endmodule

bind kmeans_cluster_engine_core kce_checker u_kce_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .pready       (pready)
);
